>>> design/sds_pkg.sv
package sds_pkg;

  localparam int SCENT_W   = 15;
  localparam int GEOM_W    = 12;   // holds widths and row positions up to 1024 + flush rows
  localparam int ROW_W     = 11;
  localparam int RW_W      = 8;
  localparam int RC_W      = 11;
  localparam int GAIN_W    = 8;
  localparam int THR_W     = 15;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_ROW_WIDTH_DEF = 128;
  localparam int SAMPLE_BITS_DEF   = 16;

  localparam int GEOM_MIN  = 3;
  localparam int ROWS_MAX  = 1024;
  localparam int SCENT_MAX = 32767;

  localparam logic [RW_W-1:0]   ROW_WIDTH_RST = RW_W'(100);
  localparam logic [RC_W-1:0]   ROW_COUNT_RST = RC_W'(100);
  localparam logic [GAIN_W-1:0] GAIN_RST      = GAIN_W'(51);
  localparam logic [THR_W-1:0]  THR_RST       = '0;

  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_WIDTH = 2'd0,
    CFG_ROW_COUNT = 2'd1,
    CFG_GAIN      = 2'd2,
    CFG_THRESHOLD = 2'd3
  } sds_cfg_e;

  // per-item control, decided at the input transfer
  typedef struct packed {
    logic emit;    // item produces a result
    logic last;    // result closes the frame, no window shift
    logic wr;      // shift window and write line memories
    logic top;     // row above the center lies inside the map
    logic bot;     // row below the center lies inside the map
    logic c0_en;   // leftmost candidate column in use
    logic c2_en;   // incoming column in use
  } sds_ctl_t;

  typedef logic [2:0][SCENT_W-1:0] sds_col3_t;

  typedef struct packed {
    logic [SCENT_W-1:0] scent;
    logic               last;
  } sds_res_t;

  function automatic logic [SCENT_W-1:0] smax(input logic [SCENT_W-1:0] a,
                                               input logic [SCENT_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

>>> design/scent_decay_spread_stencil.sv
// A result passes the line-memory read registers, the window output registers and the spread registers
// before it enters the output queue; the cell itself lags the input stream by row_width+1 items.
// Throughput: one item per cycle; an eight-entry output queue bounds the results in flight,
// and the input stalls only when that queue and the pipeline together are full.
// Reset (rst_ni, async, active low): position, window and registers to defaults;
// line memories are not cleared.
module scent_decay_spread_stencil #(
  parameter int MAX_ROW_WIDTH = sds_pkg::MAX_ROW_WIDTH_DEF,
  parameter int SAMPLE_BITS   = sds_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sds_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sds_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [SAMPLE_BITS-1:0]           scent_sample_i,
  input  logic                             is_padding_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [sds_pkg::SCENT_W-1:0]      scent_out_o,
  output logic                             frame_last_o
);

  localparam int COL_W  = $clog2(MAX_ROW_WIDTH);
  localparam int GW     = sds_pkg::GEOM_W;

  logic [sds_pkg::RW_W-1:0]   row_width_q;
  logic [sds_pkg::RC_W-1:0]   row_count_q;
  logic [sds_pkg::GAIN_W-1:0] gain_q;
  logic [sds_pkg::THR_W-1:0]  thr_q;

  logic [COL_W-1:0]           col_q, col_d;
  logic [sds_pkg::ROW_W-1:0]  row_q, row_d;

  logic [GW-1:0]              w_eff, h_eff, c_wrap, r_wrap, lc, lr;
  logic [31:0]                half;
  logic [sds_pkg::SCENT_W-1:0] d;
  logic                       emit_a, emit_b, last;
  sds_pkg::sds_ctl_t          ctl;
  logic                       acc;

  logic [sds_pkg::SCENT_W-1:0] up, mid, newc, center2;
  logic                        emit1, emit2, last2, push;
  sds_pkg::sds_col3_t          colmax2;
  sds_pkg::sds_res_t           res, head;
  logic [sds_pkg::OUT_CNT_W-1:0] cnt;
  logic [sds_pkg::OUT_CNT_W:0]   pending;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= sds_pkg::ROW_WIDTH_RST;
      row_count_q <= sds_pkg::ROW_COUNT_RST;
      gain_q      <= sds_pkg::GAIN_RST;
      thr_q       <= sds_pkg::THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sds_pkg::CFG_ROW_WIDTH: row_width_q <= cfg_data_i[sds_pkg::RW_W-1:0];
        sds_pkg::CFG_ROW_COUNT: row_count_q <= cfg_data_i[sds_pkg::RC_W-1:0];
        sds_pkg::CFG_GAIN:      gain_q      <= cfg_data_i[sds_pkg::GAIN_W-1:0];
        sds_pkg::CFG_THRESHOLD: thr_q       <= cfg_data_i[sds_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // position of this item; geometry changed while idle wraps or restarts the frame
  always_comb begin
    w_eff = GW'(row_width_q);
    if (w_eff < GW'(sds_pkg::GEOM_MIN)) begin
      w_eff = GW'(sds_pkg::GEOM_MIN);
    end else if (w_eff > GW'(MAX_ROW_WIDTH)) begin
      w_eff = GW'(MAX_ROW_WIDTH);
    end
    h_eff = GW'(row_count_q);
    if (h_eff < GW'(sds_pkg::GEOM_MIN)) begin
      h_eff = GW'(sds_pkg::GEOM_MIN);
    end else if (h_eff > GW'(sds_pkg::ROWS_MAX)) begin
      h_eff = GW'(sds_pkg::ROWS_MAX);
    end

    if (GW'(col_q) >= w_eff) begin
      c_wrap = '0;
      r_wrap = GW'(row_q) + 1'b1;
    end else begin
      c_wrap = GW'(col_q);
      r_wrap = GW'(row_q);
    end
    if (r_wrap > h_eff + 1'b1) begin
      lc = '0;
      lr = '0;
    end else begin
      lc = c_wrap;
      lr = r_wrap;
    end

    half = 32'(scent_sample_i >> 1);
    if (lr >= h_eff || is_padding_i) begin
      d = '0;
    end else if (half > 32'(sds_pkg::SCENT_MAX)) begin
      d = sds_pkg::SCENT_W'(sds_pkg::SCENT_MAX);
    end else begin
      d = half[sds_pkg::SCENT_W-1:0];
    end

    // row start finishes the last cell two rows up; otherwise the cell up-left
    emit_a    = (lc == '0) && (lr >= GW'(2));
    last      = emit_a && (lr == h_eff + 1'b1);
    emit_b    = (lc >= GW'(1)) && (lr >= GW'(1));
    ctl.emit  = emit_a | emit_b;
    ctl.last  = last;
    ctl.wr    = !last;
    ctl.top   = emit_a ? (lr >= GW'(3)) : (lr >= GW'(2));
    ctl.bot   = emit_a ? (lr <= h_eff) : (lr < h_eff);
    ctl.c0_en = emit_a | (lc >= GW'(2));
    ctl.c2_en = !emit_a;

    if (last) begin
      col_d = '0;
      row_d = '0;
    end else if (lc + 1'b1 >= w_eff) begin
      col_d = '0;
      row_d = sds_pkg::ROW_W'(lr + 1'b1);
    end else begin
      col_d = COL_W'(lc + 1'b1);
      row_d = sds_pkg::ROW_W'(lr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // results already queued or on their way through the pipeline
  assign pending    = (sds_pkg::OUT_CNT_W+1)'(cnt) + (sds_pkg::OUT_CNT_W+1)'(emit1)
                    + (sds_pkg::OUT_CNT_W+1)'(emit2) + (sds_pkg::OUT_CNT_W+1)'(push);
  assign in_stall_o = (pending >= (sds_pkg::OUT_CNT_W+1)'(sds_pkg::OUT_DEPTH));
  assign acc        = in_valid_i & !in_stall_o;

  sds_line_mem #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
    .COL_W         (COL_W)
  ) u_line_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .addr_i (lc[COL_W-1:0]),
    .wr_i   (ctl.wr),
    .d_i    (d),
    .up_o   (up),
    .mid_o  (mid),
    .new_o  (newc)
  );

  sds_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (acc),
    .ctl_i    (ctl),
    .up_i     (up),
    .mid_i    (mid),
    .new_i    (newc),
    .thr_i    (thr_q),
    .emit1_o  (emit1),
    .emit2_o  (emit2),
    .last2_o  (last2),
    .colmax_o (colmax2),
    .center_o (center2)
  );

  sds_spread u_spread (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .emit2_i  (emit2),
    .last2_i  (last2),
    .colmax_i (colmax2),
    .center_i (center2),
    .gain_i   (gain_q),
    .push_o   (push),
    .res_o    (res)
  );

  sds_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res),
    .pop_i   (!out_stall_i),
    .valid_o (out_valid_o),
    .data_o  (head),
    .cnt_o   (cnt)
  );

  assign scent_out_o  = head.scent;
  assign frame_last_o = head.last;

endmodule

>>> design/sds_line_mem.sv
module sds_line_mem #(
  parameter int MAX_ROW_WIDTH = sds_pkg::MAX_ROW_WIDTH_DEF,
  parameter int COL_W         = $clog2(MAX_ROW_WIDTH)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         acc_i,
  input  logic [COL_W-1:0]             addr_i,
  input  logic                         wr_i,
  input  logic [sds_pkg::SCENT_W-1:0]  d_i,
  output logic [sds_pkg::SCENT_W-1:0]  up_o,
  output logic [sds_pkg::SCENT_W-1:0]  mid_o,
  output logic [sds_pkg::SCENT_W-1:0]  new_o
);

  logic [sds_pkg::SCENT_W-1:0] upper_mem [MAX_ROW_WIDTH];
  logic [sds_pkg::SCENT_W-1:0] middle_mem [MAX_ROW_WIDTH];

  logic [sds_pkg::SCENT_W-1:0] up_rd_q, mid_rd_q, d_q;
  logic [sds_pkg::SCENT_W-1:0] fwd_up_q, fwd_mid_q;
  logic [COL_W-1:0]            addr_q;
  logic                        wen_q, fwd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wen_q <= 1'b0;
      fwd_q <= 1'b0;
    end else begin
      wen_q <= acc_i & wr_i;
      fwd_q <= acc_i & wen_q & (addr_q == addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      addr_q    <= addr_i;
      d_q       <= d_i;
      fwd_up_q  <= mid_o;
      fwd_mid_q <= d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      up_rd_q  <= upper_mem[addr_i];
      mid_rd_q <= middle_mem[addr_i];
    end
    if (wen_q) begin
      upper_mem[addr_q]  <= mid_o;
      middle_mem[addr_q] <= d_q;
    end
  end

  // read-modify-write on the same column in back-to-back cycles takes the pending write
  assign up_o  = fwd_q ? fwd_up_q  : up_rd_q;
  assign mid_o = fwd_q ? fwd_mid_q : mid_rd_q;
  assign new_o = d_q;

endmodule

>>> design/sds_window.sv
module sds_window (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         acc_i,
  input  sds_pkg::sds_ctl_t            ctl_i,
  input  logic [sds_pkg::SCENT_W-1:0]  up_i,
  input  logic [sds_pkg::SCENT_W-1:0]  mid_i,
  input  logic [sds_pkg::SCENT_W-1:0]  new_i,
  input  logic [sds_pkg::THR_W-1:0]    thr_i,
  output logic                         emit1_o,
  output logic                         emit2_o,
  output logic                         last2_o,
  output sds_pkg::sds_col3_t           colmax_o,
  output logic [sds_pkg::SCENT_W-1:0]  center_o
);

  logic [sds_pkg::SCENT_W-1:0] win_q [3][3];
  sds_pkg::sds_ctl_t           ctl_q;
  logic                        v_q;

  logic [sds_pkg::SCENT_W-1:0] nc [3];
  logic [sds_pkg::SCENT_W-1:0] msk [3][3];
  logic                        row_en [3];
  sds_pkg::sds_col3_t          colmax_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= 1'b0;
      ctl_q <= '0;
    end else begin
      v_q <= acc_i;
      if (acc_i) begin
        ctl_q <= ctl_i;
      end
    end
  end

  always_comb begin
    nc[0]     = up_i;
    nc[1]     = mid_i;
    nc[2]     = new_i;
    row_en[0] = ctl_q.top;
    row_en[1] = 1'b1;
    row_en[2] = ctl_q.bot;
    for (int r = 0; r < 3; r++) begin
      msk[0][r] = (row_en[r] && ctl_q.c0_en && win_q[r][1] > thr_i) ? win_q[r][1] : '0;
      msk[1][r] = (row_en[r] && win_q[r][2] > thr_i) ? win_q[r][2] : '0;
      msk[2][r] = (row_en[r] && ctl_q.c2_en && nc[r] > thr_i) ? nc[r] : '0;
    end
    for (int c = 0; c < 3; c++) begin
      colmax_d[c] = sds_pkg::smax(sds_pkg::smax(msk[c][0], msk[c][1]), msk[c][2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (v_q && ctl_q.wr) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
        win_q[r][2] <= nc[r];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit2_o <= 1'b0;
    end else begin
      emit2_o <= v_q & ctl_q.emit;
    end
  end

  // center is the same window cell for both output cases
  always_ff @(posedge clk_i) begin
    last2_o  <= ctl_q.last;
    colmax_o <= colmax_d;
    center_o <= win_q[1][2];
  end

  assign emit1_o = v_q & ctl_q.emit;

endmodule

>>> design/sds_spread.sv
module sds_spread (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         emit2_i,
  input  logic                         last2_i,
  input  sds_pkg::sds_col3_t           colmax_i,
  input  logic [sds_pkg::SCENT_W-1:0]  center_i,
  input  logic [sds_pkg::GAIN_W-1:0]   gain_i,
  output logic                         push_o,
  output sds_pkg::sds_res_t            res_o
);

  localparam int PROD_W = sds_pkg::SCENT_W + sds_pkg::GAIN_W;

  logic [sds_pkg::SCENT_W-1:0] mx_q, center_q;
  logic                        last_q;
  logic [PROD_W-1:0]           prod;
  logic [sds_pkg::SCENT_W-1:0] cand;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push_o <= 1'b0;
    end else begin
      push_o <= emit2_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q     <= sds_pkg::smax(sds_pkg::smax(colmax_i[0], colmax_i[1]), colmax_i[2]);
    center_q <= center_i;
    last_q   <= last2_i;
  end

  // floor(n*g/256) is monotonic in n: scale only the largest eligible neighbor
  always_comb begin
    prod        = PROD_W'(mx_q) * PROD_W'(gain_i);
    cand        = prod[PROD_W-1:sds_pkg::GAIN_W];
    res_o.scent = sds_pkg::smax(cand, center_q);
    res_o.last  = last_q;
  end

endmodule

>>> design/sds_out_fifo.sv
module sds_out_fifo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  sds_pkg::sds_res_t              data_i,
  input  logic                           pop_i,
  output logic                           valid_o,
  output sds_pkg::sds_res_t              data_o,
  output logic [sds_pkg::OUT_CNT_W-1:0]  cnt_o
);

  sds_pkg::sds_res_t                 buf_q [sds_pkg::OUT_DEPTH];
  logic [sds_pkg::OUT_PTR_W-1:0]     wptr_q, rptr_q;
  logic [sds_pkg::OUT_CNT_W-1:0]     cnt_q;
  logic                              do_pop;

  assign do_pop = pop_i & (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + sds_pkg::OUT_CNT_W'(push_i) - sds_pkg::OUT_CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wptr_q] <= data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = buf_q[rptr_q];
  assign cnt_o   = cnt_q;

endmodule

>>> design/sds_checker.sv
module sds_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [sds_pkg::SCENT_W-1:0]  scent_out_o,
  input logic                         frame_last_o
);

  // a refused result stays offered unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(scent_out_o) && $stable(frame_last_o))
    else $error("stalled result changed");

  // input back-pressure only comes from a backed-up output queue
  a_stall_cause: assert property (@(posedge clk_i)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output queue");

  // reset empties the queue and opens the input
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && !in_stall_o)
    else $error("reset state not clean");

  // with the output idle and no input, nothing stays blocked
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_i && !out_stall_i && !out_valid_o && $past(!out_valid_o)
    |-> !in_stall_o)
    else $error("stall without pending results");

endmodule

bind scent_decay_spread_stencil sds_checker u_sds_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .scent_out_o  (scent_out_o),
  .frame_last_o (frame_last_o)
);
